>>> rtl/rbmp_pkg.sv
package rbmp_pkg;

    // Field widths
    localparam int POS_W  = 32;
    localparam int TIME_W = 24;
    localparam int DEC_W  = 24;
    localparam int SPD_W  = 32;
    localparam int RAD_W  = 64;
    localparam int DIST_W = 64;
    localparam int MV_W   = 40;

    // Shared divider shape: 96-bit numerator, 33-bit divisor, 64-bit quotient
    localparam int NUM_W  = 96;
    localparam int DEN_W  = 33;
    localparam int QUO_W  = 64;

    // Stream payload widths
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 152;

    // Pipeline latencies of the iterative units
    localparam int SQ_LAT  = RAD_W / 2;
    localparam int DIV_LAT = QUO_W + 1;

    localparam logic [DEC_W-1:0] DECEL_RESET = 24'd32768;
    localparam logic [POS_W-1:0] POS_MAX     = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic [POS_W-1:0]        mx;
        logic [POS_W-1:0]        my;
        logic                    nx;
        logic                    ny;
        logic [TIME_W-1:0]       t;
    } t_ctx;

    typedef struct packed {
        t_ctx              ctx;
        logic [SPD_W-1:0]  s;
        logic              stop;
        logic [MV_W-1:0]   dmv;
    } t_mid;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic                    nx;
        logic                    ny;
        logic                    szero;
        logic                    stop;
        logic [POS_W-1:0]        ovx;
        logic [POS_W-1:0]        ovy;
        logic [TIME_W-1:0]       tts;
    } t_tail;

    typedef struct packed {
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  vx;
        logic [POS_W-1:0]  vy;
        logic [TIME_W-1:0] tts;
        logic              stopped;
    } t_res;

    // base + (neg ? -mag : mag), saturated to 32-bit signed
    function automatic logic [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] base,
                                                 input logic [QUO_W-1:0] mag,
                                                 input logic neg);
        logic signed [POS_W+1:0] b;
        logic signed [POS_W+1:0] m;
        logic signed [POS_W+1:0] sum;
        logic [POS_W-1:0]        res;
        b = {{2{base[POS_W-1]}}, base};
        m = {2'b00, mag[POS_W-1:0]};
        if (neg) begin
            m = -m;
        end
        sum = b + m;
        if (mag[QUO_W-1:POS_W] != '0) begin
            res = neg ? POS_MIN : POS_MAX;
        end else if (sum > $signed({2'b00, POS_MAX})) begin
            res = POS_MAX;
        end else if (sum < $signed({2'b11, POS_MIN})) begin
            res = POS_MIN;
        end else begin
            res = sum[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/rolling_ball_motion_predictor.sv
// Channel  | Ports          | Payload (low bit first)
// ---------+----------------+----------------------------------------------------
// input    | s_axis_*       | pos_x, pos_y, vel_x, vel_y, look_ahead (152 b)
// output   | m_axis_*       | pred_x, pred_y, pred_vx, pred_vy, time_to_stop;
//          |                | tuser = has_stopped
// config   | i_cfg_*        | deceleration (24 b), written on i_cfg_wen
//
// One transaction per cycle in and out while the skid register is empty; the pipeline
// depth ahead of the output register is set by the bit-per-stage square root
// and the two chained dividers of 64 restoring stages each.
// Synchronous active-low reset clears valid bits and restores deceleration 0.5.
// A stall freezes the whole pipeline once the skid register holds a result.
module rolling_ball_motion_predictor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, look_ahead
    input  logic [rbmp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pred_x, pred_y, pred_vx, pred_vy, time_to_stop
    output logic [rbmp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // has_stopped
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_wen,
    input  logic [rbmp_pkg::DEC_W-1:0]          i_cfg_wdata
);
    import rbmp_pkg::*;

    logic ce;

    // Deceleration register, zero taken as the smallest step
    logic [DEC_W-1:0] r_decel;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decel <= DECEL_RESET;
        end else if (i_cfg_wen) begin
            r_decel <= (i_cfg_wdata == '0) ? DEC_W'(1) : i_cfg_wdata;
        end
    end

    // Input unpack and magnitudes
    logic signed [POS_W-1:0] in_vx, in_vy;
    t_ctx n_c0;
    assign in_vx = s_axis_tdata[95:64];
    assign in_vy = s_axis_tdata[127:96];
    always_comb begin
        n_c0.px = s_axis_tdata[31:0];
        n_c0.py = s_axis_tdata[63:32];
        n_c0.nx = in_vx[POS_W-1];
        n_c0.ny = in_vy[POS_W-1];
        n_c0.mx = in_vx[POS_W-1] ? (~in_vx + 1'b1) : in_vx;
        n_c0.my = in_vy[POS_W-1] ? (~in_vy + 1'b1) : in_vy;
        n_c0.t  = s_axis_tdata[151:128];
    end

    // Front stages: register, square, sum
    logic r_v0, r_v1, r_v2;
    t_ctx r_c0, r_c1, r_c2;
    logic [RAD_W-1:0] r_sqx, r_sqy, r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (ce) begin
            r_v0 <= s_axis_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c0  <= n_c0;
            r_c1  <= r_c0;
            r_sqx <= r_c0.mx * r_c0.mx;
            r_sqy <= r_c0.my * r_c0.my;
            r_c2  <= r_c1;
            r_rad <= r_sqx + r_sqy;
        end
    end

    // Speed
    logic [SPD_W-1:0] sq_root;
    rbmp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_rad  (r_rad),
        .o_root (sq_root)
    );

    logic r_vq [SQ_LAT];
    t_ctx r_cq [SQ_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_LAT; k++) begin
                r_vq[k] <= 1'b0;
            end
        end else if (ce) begin
            r_vq[0] <= r_v2;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_vq[k] <= r_vq[k-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cq[0] <= r_c2;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_cq[k] <= r_cq[k-1];
            end
        end
    end

    // Kinematics stages
    logic r_vk0, r_vk1, r_vk2, r_vk3;
    t_ctx r_ck0, r_ck1, r_ck2, r_ck3;
    logic [SPD_W-1:0] r_s0, r_s1, r_s2, r_s3;
    logic [RAD_W-1:0] r_ss0, r_ss1, r_ss2, r_ss3;
    logic [47:0] r_dt0, r_vr1;
    logic [48:0] r_u1;
    logic r_stop1, r_stop2, r_stop3;
    logic [55:0] r_pul;
    logic [40:0] r_puh;
    logic [63:0] r_pvxl, r_pvyl;
    logic [47:0] r_pvxh, r_pvyh;
    logic [MV_W-1:0] r_dmv3;
    logic [63:0] r_nvx3, r_nvy3;
    logic [47:0] s16_0, s16_3;
    logic [72:0] n_pu;
    logic [79:0] n_pvx, n_pvy;

    assign s16_0 = {r_s0, 16'b0};
    assign s16_3 = {r_s3, 16'b0};
    assign n_pu  = {r_puh, 32'b0} + 73'(r_pul);
    assign n_pvx = {r_pvxh, 32'b0} + 80'(r_pvxl);
    assign n_pvy = {r_pvyh, 32'b0} + 80'(r_pvyl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vk0 <= 1'b0;
            r_vk1 <= 1'b0;
            r_vk2 <= 1'b0;
            r_vk3 <= 1'b0;
        end else if (ce) begin
            r_vk0 <= r_vq[SQ_LAT-1];
            r_vk1 <= r_vk0;
            r_vk2 <= r_vk1;
            r_vk3 <= r_vk2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            // decel * t, speed squared
            r_ck0   <= r_cq[SQ_LAT-1];
            r_s0    <= sq_root;
            r_dt0   <= r_decel * r_cq[SQ_LAT-1].t;
            r_ss0   <= sq_root * sq_root;
            // stop test, 2S - dt and S - dt
            r_ck1   <= r_ck0;
            r_s1    <= r_s0;
            r_ss1   <= r_ss0;
            r_stop1 <= (r_dt0 >= s16_0);
            r_u1    <= {s16_0, 1'b0} - {1'b0, r_dt0};
            r_vr1   <= s16_0 - r_dt0;
            // partial products
            r_ck2   <= r_ck1;
            r_s2    <= r_s1;
            r_ss2   <= r_ss1;
            r_stop2 <= r_stop1;
            r_pul   <= r_ck1.t * r_u1[31:0];
            r_puh   <= r_ck1.t * r_u1[48:32];
            r_pvxl  <= r_vr1[31:0] * r_ck1.mx;
            r_pvxh  <= r_vr1[47:32] * r_ck1.mx;
            r_pvyl  <= r_vr1[31:0] * r_ck1.my;
            r_pvyh  <= r_vr1[47:32] * r_ck1.my;
            // recombine
            r_ck3   <= r_ck2;
            r_s3    <= r_s2;
            r_ss3   <= r_ss2;
            r_stop3 <= r_stop2;
            r_dmv3  <= n_pu[72:33];
            r_nvx3  <= n_pvx[79:16];
            r_nvy3  <= n_pvy[79:16];
        end
    end

    // First divider bank: stop time, rest distance, velocity components
    logic [QUO_W-1:0] q_tts, q_sd, q_vx, q_vy;

    rbmp_div u_div_tts (
        .i_clk (i_clk), .i_ce (ce),
        .i_num ({48'b0, s16_3}),
        .i_den ({9'b0, r_decel}),
        .o_quo (q_tts)
    );
    rbmp_div u_div_sd (
        .i_clk (i_clk), .i_ce (ce),
        .i_num ({32'b0, r_ss3}),
        .i_den ({8'b0, r_decel, 1'b0}),
        .o_quo (q_sd)
    );
    rbmp_div u_div_vx (
        .i_clk (i_clk), .i_ce (ce),
        .i_num ({32'b0, r_nvx3}),
        .i_den ({1'b0, r_s3}),
        .o_quo (q_vx)
    );
    rbmp_div u_div_vy (
        .i_clk (i_clk), .i_ce (ce),
        .i_num ({32'b0, r_nvy3}),
        .i_den ({1'b0, r_s3}),
        .o_quo (q_vy)
    );

    logic r_vm [DIV_LAT];
    t_mid r_cm [DIV_LAT];
    t_mid n_cm;
    always_comb begin
        n_cm.ctx  = r_ck3;
        n_cm.s    = r_s3;
        n_cm.stop = r_stop3;
        n_cm.dmv  = r_dmv3;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_vm[k] <= 1'b0;
            end
        end else if (ce) begin
            r_vm[0] <= r_vk3;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_vm[k] <= r_vm[k-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cm[0] <= n_cm;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_cm[k] <= r_cm[k-1];
            end
        end
    end

    // Distance select and displacement products
    t_mid m_end;
    assign m_end = r_cm[DIV_LAT-1];

    logic r_ve0, r_ve1, r_ve2;
    t_tail r_te0, r_te1, r_te2;
    logic [DIST_W-1:0] r_dist;
    logic [SPD_W-1:0] r_se0, r_se1, r_se2;
    logic [POS_W-1:0] r_mxe, r_mye;
    logic [63:0] r_dxl, r_dxh, r_dyl, r_dyh;
    logic [NUM_W-1:0] r_nx2, r_ny2;
    t_tail n_te0;

    always_comb begin
        n_te0.px    = m_end.ctx.px;
        n_te0.py    = m_end.ctx.py;
        n_te0.nx    = m_end.ctx.nx;
        n_te0.ny    = m_end.ctx.ny;
        n_te0.szero = (m_end.s == '0);
        n_te0.stop  = m_end.stop;
        n_te0.ovx   = m_end.stop ? '0 : sat_add('0, q_vx, m_end.ctx.nx);
        n_te0.ovy   = m_end.stop ? '0 : sat_add('0, q_vy, m_end.ctx.ny);
        n_te0.tts   = (q_tts[QUO_W-1:TIME_W] != '0) ? '1 : q_tts[TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve0 <= 1'b0;
            r_ve1 <= 1'b0;
            r_ve2 <= 1'b0;
        end else if (ce) begin
            r_ve0 <= r_vm[DIV_LAT-1];
            r_ve1 <= r_ve0;
            r_ve2 <= r_ve1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_te0  <= n_te0;
            r_se0  <= m_end.s;
            r_mxe  <= m_end.ctx.mx;
            r_mye  <= m_end.ctx.my;
            r_dist <= m_end.stop ? q_sd : {{(DIST_W-MV_W){1'b0}}, m_end.dmv};
            r_te1  <= r_te0;
            r_se1  <= r_se0;
            r_dxl  <= r_dist[31:0] * r_mxe;
            r_dxh  <= r_dist[63:32] * r_mxe;
            r_dyl  <= r_dist[31:0] * r_mye;
            r_dyh  <= r_dist[63:32] * r_mye;
            r_te2  <= r_te1;
            r_se2  <= r_se1;
            r_nx2  <= {r_dxh, 32'b0} + NUM_W'(r_dxl);
            r_ny2  <= {r_dyh, 32'b0} + NUM_W'(r_dyl);
        end
    end

    // Second divider bank: displacement components
    logic [QUO_W-1:0] q_px, q_py;
    rbmp_div u_div_px (
        .i_clk (i_clk), .i_ce (ce),
        .i_num (r_nx2),
        .i_den ({1'b0, r_se2}),
        .o_quo (q_px)
    );
    rbmp_div u_div_py (
        .i_clk (i_clk), .i_ce (ce),
        .i_num (r_ny2),
        .i_den ({1'b0, r_se2}),
        .o_quo (q_py)
    );

    logic r_vt [DIV_LAT];
    t_tail r_ct [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_vt[k] <= 1'b0;
            end
        end else if (ce) begin
            r_vt[0] <= r_ve2;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_vt[k] <= r_vt[k-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ct[0] <= r_te2;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_ct[k] <= r_ct[k-1];
            end
        end
    end

    // Final assembly
    t_tail t_end;
    t_res  n_res;
    assign t_end = r_ct[DIV_LAT-1];
    always_comb begin
        n_res.px      = t_end.szero ? t_end.px : sat_add(t_end.px, q_px, t_end.nx);
        n_res.py      = t_end.szero ? t_end.py : sat_add(t_end.py, q_py, t_end.ny);
        n_res.vx      = t_end.szero ? '0 : t_end.ovx;
        n_res.vy      = t_end.szero ? '0 : t_end.ovy;
        n_res.tts     = t_end.szero ? '0 : t_end.tts;
        n_res.stopped = t_end.szero | t_end.stop;
    end

    logic r_vf;
    t_res r_fd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (ce) begin
            r_vf <= r_vt[DIV_LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_fd <= n_res;
        end
    end

    // Output register with skid
    logic r_ov, r_sv;
    t_res r_od, r_sd;
    logic taken, push;

    assign ce            = ~r_sv;
    assign s_axis_tready = ce;
    assign taken         = r_ov & m_axis_tready;
    assign push          = ce & r_vf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (taken) begin
                r_sv <= 1'b0;
            end
        end else if (push) begin
            if (r_ov && !taken) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (taken) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (taken) begin
                r_od <= r_sd;
            end
        end else if (push) begin
            if (r_ov && !taken) begin
                r_sd <= r_fd;
            end else begin
                r_od <= r_fd;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_od.tts, r_od.vy, r_od.vx, r_od.py, r_od.px};
    assign m_axis_tuser  = r_od.stopped;

    // Skid only ever fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a result while output register is empty");

    // A result arriving at a blocked output lands in the skid
    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready && r_vf && !r_sv) |=> r_sv)
        else $error("result lost at blocked output");

    // The skid drains only when the output is taken
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !m_axis_tready) |=> r_sv)
        else $error("skid released without output transaction");

    // A stopped ball has no velocity
    a_stopped_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_od.stopped) |-> (r_od.vx == '0 && r_od.vy == '0))
        else $error("stopped prediction carries velocity");

endmodule

>>> rtl/rbmp_sqrt.sv
module rbmp_sqrt (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [rbmp_pkg::RAD_W-1:0] i_rad,
    output logic [rbmp_pkg::SPD_W-1:0] o_root
);
    import rbmp_pkg::*;

    // One root bit per stage, radicand remainder and partial root travel together
    logic [RAD_W-1:0] r_x [SQ_LAT];
    logic [RAD_W-1:0] r_r [SQ_LAT];
    logic [RAD_W-1:0] a_x [SQ_LAT+1];
    logic [RAD_W-1:0] a_r [SQ_LAT+1];
    logic [RAD_W-1:0] n_x [SQ_LAT];
    logic [RAD_W-1:0] n_r [SQ_LAT];

    always_comb begin
        a_x[0] = i_rad;
        a_r[0] = '0;
        for (int k = 0; k < SQ_LAT; k++) begin
            a_x[k+1] = r_x[k];
            a_r[k+1] = r_r[k];
        end
    end

    // Per-stage trial subtract
    always_comb begin
        logic [RAD_W:0]   trial;
        logic [RAD_W-1:0] bitv;
        for (int k = 0; k < SQ_LAT; k++) begin
            bitv  = {{(RAD_W-1){1'b0}}, 1'b1} << (RAD_W - 2 - 2 * k);
            trial = {1'b0, a_r[k]} + {1'b0, bitv};
            if ({1'b0, a_x[k]} >= trial) begin
                n_x[k] = a_x[k] - trial[RAD_W-1:0];
                n_r[k] = (a_r[k] >> 1) + bitv;
            end else begin
                n_x[k] = a_x[k];
                n_r[k] = a_r[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < SQ_LAT; k++) begin
                r_x[k] <= n_x[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_root = r_r[SQ_LAT-1][SPD_W-1:0];

endmodule

>>> rtl/rbmp_div.sv
module rbmp_div (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [rbmp_pkg::NUM_W-1:0] i_num,
    input  logic [rbmp_pkg::DEN_W-1:0] i_den,
    output logic [rbmp_pkg::QUO_W-1:0] o_quo
);
    import rbmp_pkg::*;

    // Entry stage: overflow check and initial remainder
    logic [DEN_W-1:0] r_rem0;
    logic [QUO_W-1:0] r_w0;
    logic [DEN_W-1:0] r_den0;
    logic             r_sat0;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem0 <= {1'b0, i_num[NUM_W-1:QUO_W]};
            r_w0   <= i_num[QUO_W-1:0];
            r_den0 <= i_den;
            r_sat0 <= ({1'b0, i_num[NUM_W-1:QUO_W]} >= i_den);
        end
    end

    // Restoring stages: dividend bits shift out of w as quotient bits shift in
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_w   [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic             r_sat [QUO_W];
    logic [DEN_W-1:0] a_rem [QUO_W+1];
    logic [QUO_W-1:0] a_w   [QUO_W+1];
    logic [DEN_W-1:0] a_den [QUO_W+1];
    logic             a_sat [QUO_W+1];
    logic [DEN_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_w   [QUO_W];

    always_comb begin
        a_rem[0] = r_rem0;
        a_w[0]   = r_w0;
        a_den[0] = r_den0;
        a_sat[0] = r_sat0;
        for (int k = 0; k < QUO_W; k++) begin
            a_rem[k+1] = r_rem[k];
            a_w[k+1]   = r_w[k];
            a_den[k+1] = r_den[k];
            a_sat[k+1] = r_sat[k];
        end
    end

    always_comb begin
        logic [DEN_W:0] rr;
        logic           ge;
        for (int k = 0; k < QUO_W; k++) begin
            rr       = {a_rem[k], a_w[k][QUO_W-1]};
            ge       = (rr >= {1'b0, a_den[k]});
            n_rem[k] = ge ? DEN_W'(rr - {1'b0, a_den[k]}) : rr[DEN_W-1:0];
            n_w[k]   = {a_w[k][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_w[k]   <= n_w[k];
                r_den[k] <= a_den[k];
                r_sat[k] <= a_sat[k];
            end
        end
    end

    assign o_quo = a_sat[QUO_W] ? '1 : a_w[QUO_W];

endmodule

>>> tb/tb_rolling_ball_motion_predictor.sv
module tb_rolling_ball_motion_predictor;
    import rbmp_pkg::*;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  SETTLE       = 260;
    localparam int  LONG_HOLD    = 700;
    localparam logic [49:0] QUOT_CAP_M1 = '1;

    typedef struct packed {
        logic [TIME_W-1:0]       t;
        logic signed [POS_W-1:0] vy;
        logic signed [POS_W-1:0] vx;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] px;
    } ball_t;

    typedef struct {
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  vx;
        logic [POS_W-1:0]  vy;
        logic [TIME_W-1:0] tts;
        logic              stopped;
    } forecast_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    i_cfg_wen;
    logic [DEC_W-1:0]        i_cfg_wdata;

    ball_t     ball_q[$];
    forecast_t forecast_q[$];
    logic [DEC_W-1:0] decel;
    int        sender_idle_pct;
    int        recv_stall_pct;
    bit        pressure_on;
    bit        held_once;
    int        hold_left;
    int        cycles;
    int        errors;

    rolling_ball_motion_predictor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // floor(a*b/den), clipped at 2^50
    function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
                                                input logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, den};
        if (q > {78'd0, QUOT_CAP_M1})
            q = 128'd1 << 50;
        return q[63:0];
    endfunction

    function automatic logic [63:0] speed_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= x)
                r = b;
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] clip32(input logic signed [71:0] v);
        if (v > 72'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -72'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [71:0] signed_mag(input logic [63:0] m, input logic neg);
        logic signed [71:0] v;
        v = $signed({8'd0, m});
        return neg ? -v : v;
    endfunction

    // Constant-deceleration forecast for one ball state
    function automatic forecast_t forecast(input ball_t b, input logic [DEC_W-1:0] dreg);
        forecast_t f;
        logic [63:0]  d, mx, my, s, s16, dt, travel, v, u, tts;
        logic [127:0] wide;
        logic         nx, ny;
        logic signed [71:0] ovx, ovy;
        d   = (dreg == '0) ? 64'd1 : {40'd0, dreg};
        nx  = b.vx[31];
        ny  = b.vy[31];
        mx  = nx ? 64'd0 - {{32{b.vx[31]}}, b.vx} : {32'd0, b.vx};
        my  = ny ? 64'd0 - {{32{b.vy[31]}}, b.vy} : {32'd0, b.vy};
        s   = speed_root(mx * mx + my * my);
        ovx = 0;
        ovy = 0;
        if (s == 0) begin
            f.px = b.px;
            f.py = b.py;
            f.vx = '0;
            f.vy = '0;
            f.tts = '0;
            f.stopped = 1'b1;
            return f;
        end
        s16 = s << 16;
        tts = s16 / d;
        if (tts > 64'hFF_FFFF)
            tts = 64'hFF_FFFF;
        dt = d * {40'd0, b.t};
        if (dt >= s16) begin
            travel = (s * s) / (2 * d);
            f.stopped = 1'b1;
        end else begin
            u      = 2 * s16 - dt;
            v      = s16 - dt;
            wide   = ({104'd0, b.t} * {64'd0, u}) >> 33;
            travel = wide[63:0];
            ovx    = signed_mag(scaled_quot(v, mx, s) >> 16, nx);
            ovy    = signed_mag(scaled_quot(v, my, s) >> 16, ny);
            f.stopped = 1'b0;
        end
        f.px  = clip32($signed({{40{b.px[31]}}, b.px}) +
                       signed_mag(scaled_quot(travel, mx, s), nx));
        f.py  = clip32($signed({{40{b.py[31]}}, b.py}) +
                       signed_mag(scaled_quot(travel, my, s), ny));
        f.vx  = clip32(ovx);
        f.vy  = clip32(ovy);
        f.tts = tts[23:0];
        return f;
    endfunction

    // Random ball: magnitudes spread over many octaves, full-range words now and then
    function automatic ball_t random_ball();
        ball_t b;
        b.px = $urandom;
        b.py = $urandom;
        if ($urandom_range(3) == 0) begin
            b.vx = $urandom;
            b.vy = $urandom;
            b.t  = $urandom;
        end else begin
            b.vx = $signed($urandom >> $urandom_range(31, 8));
            b.vy = $signed($urandom >> $urandom_range(31, 8));
            if ($urandom_range(1)) b.vx = -b.vx;
            if ($urandom_range(1)) b.vy = -b.vy;
            b.t  = $urandom >> $urandom_range(31, 8);
        end
        return b;
    endfunction

    function automatic ball_t mk(input int px, input int py, input int vx, input int vy,
                                 input int t);
        ball_t b;
        b.px = px; b.py = py; b.vx = vx; b.vy = vy; b.t = t[23:0];
        return b;
    endfunction

    // Cycle count and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_rolling_ball_motion_predictor: FAIL");
            $finish;
        end
    end

    // Input driver
    always @(posedge i_clk) begin
        logic  nxt_valid;
        ball_t b;
        nxt_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            nxt_valid = 1'b0;
            if (ball_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                b = ball_q.pop_front();
                s_axis_tdata <= b;
                nxt_valid = 1'b1;
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // Receiver: random stalls plus one long hold-off while pressure is on
    always @(posedge i_clk) begin
        if (pressure_on && !held_once && s_axis_tvalid) begin
            held_once <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: forecast on input transaction, compare on output transaction
    always @(posedge i_clk) begin
        forecast_t e;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            forecast_q.push_back(forecast(ball_t'(s_axis_tdata), decel));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (forecast_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors <= errors + 1;
            end else begin
                e = forecast_q.pop_front();
                if (m_axis_tdata[31:0] !== e.px || m_axis_tdata[63:32] !== e.py ||
                    m_axis_tdata[95:64] !== e.vx || m_axis_tdata[127:96] !== e.vy ||
                    m_axis_tdata[151:128] !== e.tts || m_axis_tuser !== e.stopped) begin
                    $display("%0t: mismatch exp px=%h py=%h vx=%h vy=%h tts=%h stop=%b",
                             $time, e.px, e.py, e.vx, e.vy, e.tts, e.stopped);
                    $display("%0t:          got px=%h py=%h vx=%h vy=%h tts=%h stop=%b",
                             $time, m_axis_tdata[31:0], m_axis_tdata[63:32],
                             m_axis_tdata[95:64], m_axis_tdata[127:96],
                             m_axis_tdata[151:128], m_axis_tuser);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic drain();
        wait (ball_q.size() == 0 && !s_axis_tvalid && forecast_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_decel(input logic [DEC_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        decel        = v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    task automatic run_phase(input logic [DEC_W-1:0] dv, input int idle, input int stall,
                             input int n);
        write_decel(dv);
        sender_idle_pct = idle;
        recv_stall_pct  = stall;
        for (int i = 0; i < n; i++)
            ball_q.push_back(random_ball());
        drain();
    endtask

    initial begin
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        i_cfg_wen       = 1'b0;
        i_cfg_wdata     = '0;
        decel           = DECEL_RESET;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        pressure_on     = 1'b0;
        held_once       = 1'b0;
        hold_left       = 0;
        cycles          = 0;
        errors          = 0;
        i_rst_n         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero speed, extreme fields, stop boundary, tiny speeds
        ball_q.push_back(mk(32'h1234_5678, -5, 0, 0, 32'h00FF_FFFF));
        ball_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        ball_q.push_back(mk(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000));
        ball_q.push_back(mk(0, 0, 32'h8000_0000, 0, 0));
        ball_q.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h00FF_FFFF));
        ball_q.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h8000_0001,
                            32'h0000_0001));
        ball_q.push_back(mk(0, 0, 32'h0001_0000, 0, 32'h0002_0000));
        ball_q.push_back(mk(0, 0, 32'h0001_0000, 0, 32'h0001_FFFF));
        ball_q.push_back(mk(0, 0, 32'h0001_0000, 0, 32'h0002_0001));
        ball_q.push_back(mk(100, -100, -32'h0003_0000, 32'h0004_0000, 32'h0001_0000));
        ball_q.push_back(mk(0, 0, 1, 0, 32'h00FF_FFFF));
        ball_q.push_back(mk(0, 0, 0, -1, 0));
        ball_q.push_back(mk(0, 0, 1, 1, 32'h0000_8000));
        ball_q.push_back(mk(-7, 7, -32'h0002_0000, -32'h0002_0000, 32'h0000_4000));
        ball_q.push_back(mk(32'h7FFF_0000, 0, 32'h0100_0000, 0, 32'h0010_0000));
        ball_q.push_back(mk(32'h8000_FFFF, 0, -32'h0100_0000, 0, 32'h0010_0000));
        for (int i = 0; i < 80; i++)
            ball_q.push_back(random_ball());
        drain();

        run_phase(24'd1, 70, 0, 100);
        pressure_on = 1'b1;
        run_phase(24'hFF_FFFF, 0, 70, 100);
        pressure_on = 1'b0;
        run_phase(24'd0, 20, 20, 100);
        run_phase(24'($urandom_range(24'hFF_FFFF, 1)), 0, 0, 50);
        run_phase(DECEL_RESET, 20, 20, 50);

        if (errors == 0)
            $display("tb_rolling_ball_motion_predictor: PASS");
        else
            $display("tb_rolling_ball_motion_predictor: FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/rbmp_pkg.sv
rtl/rbmp_sqrt.sv
rtl/rbmp_div.sv
rtl/rolling_ball_motion_predictor.sv
tb/tb_rolling_ball_motion_predictor.sv
